FILE: rtl/itoa_pkg.sv
// shared types, constants and the shift-add-3 step for the integer to text converter
`default_nettype none

package itoa_pkg;

    // field and datapath widths
    localparam int MAG_W         = 32;
    localparam int DIGITS        = 10;
    localparam int BCD_W         = 4 * DIGITS;
    localparam int BITS_PER_STEP = 4;
    localparam int ITER_W        = 3;
    localparam int REMAIN_W      = 4;

    // index of the last conversion step: MAG_W / BITS_PER_STEP - 1
    localparam logic [ITER_W-1:0]   ITER_LAST   = ITER_W'(MAG_W / BITS_PER_STEP - 1);
    localparam logic [REMAIN_W-1:0] REMAIN_INIT = REMAIN_W'(DIGITS);
    localparam logic [REMAIN_W-1:0] REMAIN_ONE  = REMAIN_W'(1);

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGITS
    } itoa_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic emit_digit;
        logic skip;
    } itoa_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic slot_free;
        logic conv_done;
        logic neg;
        logic lead;
        logic top_zero;
        logic one_left;
    } itoa_status_t;

    // one binary bit into the bcd register: add 3 to every digit above 4, then shift
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd[4*d +: 4] > 4'd4)
            begin
                adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/itoa_ctrl.sv
// controller state machine for the integer to text converter
`default_nettype none

module itoa_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire itoa_pkg::itoa_status_t st,
    output itoa_pkg::itoa_cmd_t         cmd
);
    import itoa_pkg::*;

    itoa_state_t state_reg;
    itoa_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
                if (st.conv_done)
                begin
                    state_next = st.neg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (st.slot_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (!st.lead && st.top_zero && !st.one_left)
                begin
                    cmd.skip = 1'b1;
                end
                else if (st.slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (st.one_left)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/itoa_dp.sv
// datapath: magnitude, bcd conversion, digit scan and output word register
`default_nettype none

module itoa_dp (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic signed [31:0]     value,
    input  wire itoa_pkg::itoa_cmd_t    cmd,
    output itoa_pkg::itoa_status_t      st,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  text_char,
    output logic                        is_last
);
    import itoa_pkg::*;

    logic [MAG_W-1:0]    raw;
    logic [MAG_W-1:0]    mag;
    logic [MAG_W-1:0]    bin_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    bcd_step;
    logic                neg_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic [REMAIN_W-1:0] remain_reg;
    logic                lead_reg;
    logic                out_valid_reg;
    logic [7:0]          char_reg;
    logic                last_reg;
    logic [3:0]          top_digit;

    // magnitude as unsigned negation
    assign raw = value;
    assign mag = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;

    // four shift-add-3 steps per cycle, msb first
    always_comb
    begin
        bcd_step = bcd_reg;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            bcd_step = dd_step(bcd_step, bin_reg[MAG_W-1-k]);
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // status to controller
    assign st.slot_free = !out_valid_reg || !out_stall;
    assign st.conv_done = (iter_reg == ITER_LAST);
    assign st.neg       = neg_reg;
    assign st.lead      = lead_reg;
    assign st.top_zero  = (top_digit == 4'd0);
    assign st.one_left  = (remain_reg == REMAIN_ONE);

    // control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg      <= '0;
            remain_reg    <= REMAIN_INIT;
            lead_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                iter_reg   <= '0;
                remain_reg <= REMAIN_INIT;
                lead_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                begin
                    iter_reg <= iter_reg + ITER_W'(1);
                end
                if (cmd.skip || cmd.emit_digit)
                begin
                    remain_reg <= remain_reg - REMAIN_W'(1);
                end
                if (cmd.emit_digit)
                begin
                    lead_reg <= 1'b1;
                end
            end
            if (cmd.emit_sign || cmd.emit_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= mag;
            bcd_reg <= '0;
            neg_reg <= raw[MAG_W-1];
        end
        else if (cmd.step)
        begin
            bin_reg <= {bin_reg[MAG_W-1-BITS_PER_STEP:0], BITS_PER_STEP'(0)};
            bcd_reg <= bcd_step;
        end
        else if (cmd.skip || cmd.emit_digit)
        begin
            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
        end
        if (cmd.emit_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= CHAR_ZERO + {4'd0, top_digit};
            last_reg <= st.one_left;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign is_last   = last_reg;

    // a last word is always a digit
    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (char_reg >= CHAR_ZERO && char_reg <= CHAR_NINE))
        else $error("last word is not a digit");

    // a load restarts the counters
    a_load_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (iter_reg == '0 && remain_reg == REMAIN_INIT && !lead_reg))
        else $error("load did not reset counters");

    // leading digit is nonzero unless it is the only one
    a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && !lead_reg && remain_reg != REMAIN_ONE) |-> (top_digit != 4'd0))
        else $error("leading zero emitted");

    // words are only written into a free slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_reg || !out_stall))
        else $error("output word overwritten");

endmodule

`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per output word.
// Accept, then shift-add-3 at four bits per cycle, then the sign word for a negative value.
// Digit scan walks all ten bcd slots one per cycle, skipping leading zeros and emitting digits;
// the sign and each digit are emitted only when the output register is free.
// A new item is taken only after the last digit is written into the output register.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and drops out_valid.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              text_char,
    output logic                    is_last
);
    import itoa_pkg::*;

    itoa_cmd_t    cmd;
    itoa_status_t st;

    // controller
    itoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    itoa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .is_last   (is_last)
    );

endmodule

`default_nettype wire
